@@ src/assert_macros.svh @@
// Assertion helpers for the strapdown update block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_NR(label, prop, msg)
`endif
`endif

@@ src/qslu_pkg.sv @@
`default_nettype none
package qslu_pkg;

  // sequencer step control
  localparam logic [1:0] C_NEXT    = 2'd0;
  localparam logic [1:0] C_WAIT_IN = 2'd1;
  localparam logic [1:0] C_EMIT    = 2'd2;
  localparam logic [1:0] C_HOME    = 2'd3;

  // multiplier operand A
  localparam logic [3:0] A_QW  = 4'd0;
  localparam logic [3:0] A_QX  = 4'd1;
  localparam logic [3:0] A_QY  = 4'd2;
  localparam logic [3:0] A_QZ  = 4'd3;
  localparam logic [3:0] A_M   = 4'd4;
  localparam logic [3:0] A_P   = 4'd5;
  localparam logic [3:0] A_Q   = 4'd6;
  localparam logic [3:0] A_R   = 4'd7;
  localparam logic [3:0] A_RHI = 4'd8;
  localparam logic [3:0] A_RLO = 4'd9;

  // multiplier operand B
  localparam logic [2:0] B_QW  = 3'd0;
  localparam logic [2:0] B_QX  = 3'd1;
  localparam logic [2:0] B_QY  = 3'd2;
  localparam logic [2:0] B_QZ  = 3'd3;
  localparam logic [2:0] B_VEL = 3'd4;
  localparam logic [2:0] B_TS  = 3'd5;

  // accumulator operation
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // writeback target
  localparam logic [2:0] WB_NONE  = 3'd0;
  localparam logic [2:0] WB_M     = 3'd1;
  localparam logic [2:0] WB_PRATE = 3'd2;
  localparam logic [2:0] WB_VRATE = 3'd3;
  localparam logic [2:0] WB_POS   = 3'd4;
  localparam logic [2:0] WB_VEL   = 3'd5;

  localparam logic [15:0] TIME_STEP_RESET = 16'd655;
  localparam int QUAT_FRAC = 14;
  localparam int RATE_FRAC = 12;
  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [1:0] cond;
    logic [3:0] a_sel;
    logic [3:0] a_idx;
    logic [2:0] b_sel;
    logic [1:0] b_idx;
    logic [1:0] acc;
    logic       dbl;
    logic       hi;
    logic [2:0] wb;
    logic [3:0] w_idx;
  } uword_t;

  typedef struct packed {
    logic [1:0] acc;
    logic       dbl;
    logic       hi;
    logic [2:0] wb;
    logic [3:0] w_idx;
  } ctl_t;

  function automatic uword_t ctl(input logic [1:0] cond);
    uword_t w;
    w = '0;
    w.cond = cond;
    return w;
  endfunction

  function automatic uword_t mac(input logic [3:0] a_sel, input logic [3:0] a_idx,
                                 input logic [2:0] b_sel, input logic [1:0] b_idx,
                                 input logic [1:0] acc, input logic dbl, input logic hi,
                                 input logic [2:0] wb, input logic [3:0] w_idx);
    uword_t w;
    w.cond  = C_NEXT;
    w.a_sel = a_sel;
    w.a_idx = a_idx;
    w.b_sel = b_sel;
    w.b_idx = b_idx;
    w.acc   = acc;
    w.dbl   = dbl;
    w.hi    = hi;
    w.wb    = wb;
    w.w_idx = w_idx;
    return w;
  endfunction

  // quaternion product
  function automatic uword_t qq(input logic [3:0] a, input logic [2:0] b,
                                input logic [1:0] acc, input logic dbl,
                                input logic [2:0] wb, input logic [3:0] wi);
    return mac(a, 4'd0, b, 2'd0, acc, dbl, 1'b0, wb, wi);
  endfunction

  // matrix entry times body velocity
  function automatic uword_t mv(input logic [3:0] mi, input logic [1:0] vi,
                                input logic [1:0] acc, input logic [2:0] wb,
                                input logic [3:0] wi);
    return mac(A_M, mi, B_VEL, vi, acc, 1'b0, 1'b0, wb, wi);
  endfunction

  // body rate times body velocity
  function automatic uword_t rv(input logic [3:0] a, input logic [1:0] vi,
                                input logic [1:0] acc, input logic [2:0] wb,
                                input logic [3:0] wi);
    return mac(a, 4'd0, B_VEL, vi, acc, 1'b0, 1'b0, wb, wi);
  endfunction

  // rate times time step, upper part then lower part
  function automatic uword_t ts(input logic [3:0] ri, input logic lo,
                                input logic [2:0] wb, input logic [3:0] wi);
    if (lo) begin
      return mac(A_RLO, ri, B_TS, 2'd0, ACC_ADD, 1'b0, 1'b0, wb, wi);
    end
    return mac(A_RHI, ri, B_TS, 2'd0, ACC_LOAD, 1'b0, 1'b1, WB_NONE, 4'd0);
  endfunction

  function automatic uword_t prog(input logic [5:0] step);
    uword_t w;
    unique case (step)
      6'd0:  w = ctl(C_WAIT_IN);
      // m00 = w2 + x2 - y2 - z2
      6'd1:  w = qq(A_QW, B_QW, ACC_LOAD, 1'b0, WB_NONE, 4'd0);
      6'd2:  w = qq(A_QX, B_QX, ACC_ADD,  1'b0, WB_NONE, 4'd0);
      6'd3:  w = qq(A_QY, B_QY, ACC_SUB,  1'b0, WB_NONE, 4'd0);
      6'd4:  w = qq(A_QZ, B_QZ, ACC_SUB,  1'b0, WB_M,    4'd0);
      // m01 = 2(xy - wz)
      6'd5:  w = qq(A_QX, B_QY, ACC_LOAD, 1'b1, WB_NONE, 4'd0);
      6'd6:  w = qq(A_QW, B_QZ, ACC_SUB,  1'b1, WB_M,    4'd1);
      // m02 = 2(xz + wy)
      6'd7:  w = qq(A_QX, B_QZ, ACC_LOAD, 1'b1, WB_NONE, 4'd0);
      6'd8:  w = qq(A_QW, B_QY, ACC_ADD,  1'b1, WB_M,    4'd2);
      // m10 = 2(xy + wz)
      6'd9:  w = qq(A_QX, B_QY, ACC_LOAD, 1'b1, WB_NONE, 4'd0);
      6'd10: w = qq(A_QW, B_QZ, ACC_ADD,  1'b1, WB_M,    4'd3);
      // m11 = w2 - x2 + y2 - z2
      6'd11: w = qq(A_QW, B_QW, ACC_LOAD, 1'b0, WB_NONE, 4'd0);
      6'd12: w = qq(A_QX, B_QX, ACC_SUB,  1'b0, WB_NONE, 4'd0);
      6'd13: w = qq(A_QY, B_QY, ACC_ADD,  1'b0, WB_NONE, 4'd0);
      6'd14: w = qq(A_QZ, B_QZ, ACC_SUB,  1'b0, WB_M,    4'd4);
      // m12 = 2(yz - wx)
      6'd15: w = qq(A_QY, B_QZ, ACC_LOAD, 1'b1, WB_NONE, 4'd0);
      6'd16: w = qq(A_QW, B_QX, ACC_SUB,  1'b1, WB_M,    4'd5);
      // m20 = 2(xz - wy)
      6'd17: w = qq(A_QX, B_QZ, ACC_LOAD, 1'b1, WB_NONE, 4'd0);
      6'd18: w = qq(A_QW, B_QY, ACC_SUB,  1'b1, WB_M,    4'd6);
      // m21 = 2(yz + wx)
      6'd19: w = qq(A_QY, B_QZ, ACC_LOAD, 1'b1, WB_NONE, 4'd0);
      6'd20: w = qq(A_QW, B_QX, ACC_ADD,  1'b1, WB_M,    4'd7);
      // m22 = w2 - x2 - y2 + z2
      6'd21: w = qq(A_QW, B_QW, ACC_LOAD, 1'b0, WB_NONE, 4'd0);
      6'd22: w = qq(A_QX, B_QX, ACC_SUB,  1'b0, WB_NONE, 4'd0);
      6'd23: w = qq(A_QY, B_QY, ACC_SUB,  1'b0, WB_NONE, 4'd0);
      6'd24: w = qq(A_QZ, B_QZ, ACC_ADD,  1'b0, WB_M,    4'd8);
      // velocity rates: cross term plus acceleration
      6'd25: w = rv(A_R, 2'd1, ACC_LOAD, WB_NONE,  4'd0);
      6'd26: w = rv(A_Q, 2'd2, ACC_SUB,  WB_VRATE, 4'd0);
      6'd27: w = rv(A_P, 2'd2, ACC_LOAD, WB_NONE,  4'd0);
      6'd28: w = rv(A_R, 2'd0, ACC_SUB,  WB_VRATE, 4'd1);
      6'd29: w = rv(A_Q, 2'd0, ACC_LOAD, WB_NONE,  4'd0);
      6'd30: w = rv(A_P, 2'd1, ACC_SUB,  WB_VRATE, 4'd2);
      // position rates: matrix times velocity
      6'd31: w = mv(4'd0, 2'd0, ACC_LOAD, WB_NONE,  4'd0);
      6'd32: w = mv(4'd1, 2'd1, ACC_ADD,  WB_NONE,  4'd0);
      6'd33: w = mv(4'd2, 2'd2, ACC_ADD,  WB_PRATE, 4'd0);
      6'd34: w = mv(4'd3, 2'd0, ACC_LOAD, WB_NONE,  4'd0);
      6'd35: w = mv(4'd4, 2'd1, ACC_ADD,  WB_NONE,  4'd0);
      6'd36: w = mv(4'd5, 2'd2, ACC_ADD,  WB_PRATE, 4'd1);
      6'd37: w = mv(4'd6, 2'd0, ACC_LOAD, WB_NONE,  4'd0);
      6'd38: w = mv(4'd7, 2'd1, ACC_ADD,  WB_NONE,  4'd0);
      6'd39: w = mv(4'd8, 2'd2, ACC_ADD,  WB_PRATE, 4'd2);
      // Euler steps, velocity first
      6'd40: w = ts(4'd3, 1'b0, WB_NONE, 4'd0);
      6'd41: w = ts(4'd3, 1'b1, WB_VEL,  4'd0);
      6'd42: w = ts(4'd4, 1'b0, WB_NONE, 4'd0);
      6'd43: w = ts(4'd4, 1'b1, WB_VEL,  4'd1);
      6'd44: w = ts(4'd5, 1'b0, WB_NONE, 4'd0);
      6'd45: w = ts(4'd5, 1'b1, WB_VEL,  4'd2);
      6'd46: w = ts(4'd0, 1'b0, WB_NONE, 4'd0);
      6'd47: w = ts(4'd0, 1'b1, WB_POS,  4'd0);
      6'd48: w = ts(4'd1, 1'b0, WB_NONE, 4'd0);
      6'd49: w = ts(4'd1, 1'b1, WB_POS,  4'd1);
      6'd50: w = ts(4'd2, 1'b0, WB_NONE, 4'd0);
      6'd51: w = ts(4'd2, 1'b1, WB_POS,  4'd2);
      // drain the multiply and writeback stages
      6'd52: w = ctl(C_NEXT);
      6'd53: w = ctl(C_NEXT);
      6'd54: w = ctl(C_EMIT);
      default: w = ctl(C_HOME);
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > S32_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (x < S32_MIN) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

@@ src/quaternion_strapdown_linear_update.sv @@
// Each input beat runs the 55-step program that drives a single 24x32 multiplier and
// accumulator (51 multiply steps plus accept, drain and emit steps). m_axis_tvalid is
// registered from the emit step; a new beat is taken only back at the accept step.
// A new beat is taken while the previous result still waits on m_axis_tready.
// Reset (rst, synchronous, active high): position and velocity cleared, time_step set to
// 655, sequencer at its accept step, output empty. No clearing pass.
`default_nettype none
`include "assert_macros.svh"
module quaternion_strapdown_linear_update #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, roll_rate, pitch_rate, yaw_rate, accel_x,
  // accel_y, accel_z
  input  wire logic [207:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x, pos_y, pos_z, vel_u, vel_v, vel_w
  output logic [191:0]      m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata
);

  logic [5:0]   step;
  logic [5:0]   step_next;
  qslu_pkg::uword_t uw;
  logic         in_beat;
  logic         out_free;
  logic         emit;
  logic [15:0]  time_step;

  logic signed [15:0] quat [4];
  logic signed [15:0] brate [3];
  logic signed [31:0] accel [3];
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [19:0] m [9];
  logic signed [39:0] rate [6];

  logic signed [23:0] a_val;
  logic signed [31:0] b_val;
  logic signed [55:0] prod;
  qslu_pkg::ctl_t     s1;
  qslu_pkg::ctl_t     s2;
  logic signed [63:0] acc;
  logic signed [63:0] acc_next;
  logic signed [63:0] term;

  logic signed [63:0] sh_q;
  logic signed [63:0] vr_sum;
  logic signed [63:0] adv_sum;
  logic signed [31:0] old_val;
  logic [2:0]         vr_idx;
  logic               pipe_idle;

  assign uw            = qslu_pkg::prog(step);
  assign s_axis_tready = (uw.cond == qslu_pkg::C_WAIT_IN);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = (uw.cond == qslu_pkg::C_EMIT) && out_free;
  assign pipe_idle     = (s1.wb == qslu_pkg::WB_NONE) && (s2.wb == qslu_pkg::WB_NONE);

  always_comb begin
    unique case (uw.cond)
      qslu_pkg::C_NEXT:    step_next = step + 6'd1;
      qslu_pkg::C_WAIT_IN: step_next = in_beat ? step + 6'd1 : step;
      qslu_pkg::C_EMIT:    step_next = out_free ? 6'd0 : step;
      qslu_pkg::C_HOME:    step_next = 6'd0;
      default:             step_next = 6'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 6'd0;
      time_step <= qslu_pkg::TIME_STEP_RESET;
    end else begin
      step <= step_next;
      if (cfg_we) begin
        time_step <= cfg_wdata;
      end
    end
  end

  // hold the input beat for the whole program
  always_ff @(posedge clk) begin
    if (in_beat) begin
      quat[0]  <= s_axis_tdata[15:0];
      quat[1]  <= s_axis_tdata[31:16];
      quat[2]  <= s_axis_tdata[47:32];
      quat[3]  <= s_axis_tdata[63:48];
      brate[0] <= s_axis_tdata[79:64];
      brate[1] <= s_axis_tdata[95:80];
      brate[2] <= s_axis_tdata[111:96];
      accel[0] <= s_axis_tdata[143:112];
      accel[1] <= s_axis_tdata[175:144];
      accel[2] <= s_axis_tdata[207:176];
    end
  end

  always_comb begin
    case (uw.a_sel)
      qslu_pkg::A_QW:  a_val = 24'(quat[0]);
      qslu_pkg::A_QX:  a_val = 24'(quat[1]);
      qslu_pkg::A_QY:  a_val = 24'(quat[2]);
      qslu_pkg::A_QZ:  a_val = 24'(quat[3]);
      qslu_pkg::A_M:   a_val = 24'(m[uw.a_idx]);
      qslu_pkg::A_P:   a_val = 24'(brate[0]);
      qslu_pkg::A_Q:   a_val = 24'(brate[1]);
      qslu_pkg::A_R:   a_val = 24'(brate[2]);
      qslu_pkg::A_RHI: a_val = rate[uw.a_idx[2:0]][39:16];
      qslu_pkg::A_RLO: a_val = {8'd0, rate[uw.a_idx[2:0]][15:0]};
      default:         a_val = '0;
    endcase
    case (uw.b_sel)
      qslu_pkg::B_QW:  b_val = 32'(quat[0]);
      qslu_pkg::B_QX:  b_val = 32'(quat[1]);
      qslu_pkg::B_QY:  b_val = 32'(quat[2]);
      qslu_pkg::B_QZ:  b_val = 32'(quat[3]);
      qslu_pkg::B_VEL: b_val = vel[uw.b_idx];
      qslu_pkg::B_TS:  b_val = {16'd0, time_step};
      default:         b_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= a_val * b_val;
  end

  always_comb begin
    term = 64'(prod);
    if (s1.hi) begin
      term = term <<< 16;
    end else if (s1.dbl) begin
      term = term <<< 1;
    end
    case (s1.acc)
      qslu_pkg::ACC_LOAD: acc_next = term;
      qslu_pkg::ACC_ADD:  acc_next = acc + term;
      qslu_pkg::ACC_SUB:  acc_next = acc - term;
      default:            acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // advance control one stage per datapath stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= {uw.acc, uw.dbl, uw.hi, uw.wb, uw.w_idx};
      s2 <= s1;
    end
  end

  always_comb begin
    sh_q    = acc >>> qslu_pkg::QUAT_FRAC;
    vr_sum  = (acc >>> qslu_pkg::RATE_FRAC) + 64'(accel[s2.w_idx[1:0]]);
    vr_idx  = {1'b0, s2.w_idx[1:0]} + 3'd3;
    old_val = (s2.wb == qslu_pkg::WB_POS) ? pos[s2.w_idx[1:0]] : vel[s2.w_idx[1:0]];
    adv_sum = 64'(old_val) + (acc >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    unique case (s2.wb)
      qslu_pkg::WB_M:     m[s2.w_idx] <= sh_q[19:0];
      qslu_pkg::WB_PRATE: rate[s2.w_idx[2:0]] <= sh_q[39:0];
      qslu_pkg::WB_VRATE: rate[vr_idx] <= vr_sum[39:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      unique case (s2.wb)
        qslu_pkg::WB_POS: pos[s2.w_idx[1:0]] <= qslu_pkg::sat32(adv_sum);
        qslu_pkg::WB_VEL: vel[s2.w_idx[1:0]] <= qslu_pkg::sat32(adv_sum);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
    end
  end

  `ASSERT_CLK(a_idle_drained, s_axis_tready |-> pipe_idle, "writeback pending at accept")
  `ASSERT_CLK(a_emit_free, emit |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
  `ASSERT_CLK(a_emit_home, emit |=> (m_axis_tvalid && step == 6'd0), "no return to accept step")

endmodule
`default_nettype wire
